@@ src/rpd_pkg.sv @@
// rpd_pkg: shared types, constants and the crc-8 byte step for the rs-485 deframer
// no dependencies
package rpd_pkg;

  // packet kinds as reported on the result channel
  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_VAR = 2'd1;
  localparam logic [1:0] KIND_ROM = 2'd2;
  localparam logic [1:0] KIND_HEX = 2'd3;

  // signature and threshold characters
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_X = 8'h58;

  // boot command code
  localparam logic [7:0] CMD_BOOT = 8'd24;

  // crc-8 constants, reflected polynomial form
  localparam logic [7:0] CRC_XOR  = 8'h18;
  localparam logic [7:0] CRC_TOP  = 8'h80;
  localparam logic [7:0] CRC_MASK = 8'h7F;

  // register index of device_id
  localparam logic REG_DEVICE_ID = 1'b0;

  // one result item
  typedef struct packed {
    logic [1:0]  packet_kind;
    logic        addressed_here;
    logic [7:0]  command_code;
    logic [15:0] command_tag;
    logic [63:0] hex_payload;
    logic        payload_taken;
    logic [15:0] crc_error_total;
    logic [15:0] hex_total;
    logic        boot_armed_flag;
    logic [15:0] expected_hex_total;
  } res_t;

  // packet length for each kind
  function automatic logic [3:0] pkt_len(input logic [1:0] kind);
    logic [3:0] len;
    unique case (kind)
      KIND_CMD: len = 4'd8;
      KIND_VAR: len = 4'd9;
      default:  len = 4'd13;
    endcase
    return len;
  endfunction

  // one byte through the reflected crc-8, bit at a time
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] d;
    logic [7:0] c;
    logic       fb;
    d = crc ^ b;
    c = 8'h00;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[0];
      if (fb) c = c ^ CRC_XOR;
      c = (c >> 1) & CRC_MASK;
      if (fb) c = c | CRC_TOP;
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

@@ src/rpd_if.sv @@
// rpd_in_if and rpd_out_if: valid/ready channels for received bytes and results
// no package dependencies
interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_kind;
  logic        addressed_here;
  logic [7:0]  command_code;
  logic [15:0] command_tag;
  logic [63:0] hex_payload;
  logic        payload_taken;
  logic [15:0] crc_error_total;
  logic [15:0] hex_total;
  logic        boot_armed_flag;
  logic [15:0] expected_hex_total;
  modport source (output valid, output packet_kind, output addressed_here,
                  output command_code, output command_tag, output hex_payload,
                  output payload_taken, output crc_error_total, output hex_total,
                  output boot_armed_flag, output expected_hex_total, input ready);
  modport sink (input valid, input packet_kind, input addressed_here,
                input command_code, input command_tag, input hex_payload,
                input payload_taken, input crc_error_total, input hex_total,
                input boot_armed_flag, input expected_hex_total, output ready);
endinterface

@@ src/rpd_front.sv @@
// rpd_front: two-entry byte queue between the receive channel and the deframer
// no package dependencies
module rpd_front (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  output logic       q_valid,
  output logic [7:0] q_data,
  input  logic       q_pop
);

  logic [7:0] slot_r [2];
  logic       rd_r;
  logic       wr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rd_r];

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // byte storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= in_data;
  end

endmodule

@@ src/rpd_back.sv @@
// rpd_back: byte buffer, packet classifier, serial crc check, resync and result register
// depends on rpd_pkg
module rpd_back #(
  parameter int BUF_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  logic [7:0]      q_data,
  output logic            q_pop,
  input  logic [7:0]      device_id,
  output rpd_pkg::res_t   res,
  output logic            res_valid,
  input  logic            res_ready
);

  localparam int FW = $clog2(BUF_DEPTH + 1);
  localparam int IW = $clog2(BUF_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(BUF_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXAM  = 3'd1;
  localparam logic [2:0] S_CRC   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]     state_r;
  logic [7:0]     store_r [BUF_DEPTH];
  logic [FW-1:0]  fill_r;
  logic [FW-1:0]  idx_r;
  logic [7:0]     crc_r;
  logic [1:0]     kind_r;
  logic           pend_r;
  rpd_pkg::res_t  pres_r;
  logic [15:0]    err_r;
  logic [15:0]    hexc_r;
  logic           boot_r;
  logic [15:0]    exph_r;
  rpd_pkg::res_t  out_r;
  logic           out_v_r;

  logic [BUF_DEPTH-3:0] trip;
  logic                 sig_ok;
  logic [1:0]           sig_kind;
  logic [FW-1:0]        need;
  logic                 here;
  logic [7:0]           crc_nxt;
  rpd_pkg::res_t        chk_res;
  rpd_pkg::res_t        done_res;

  // three bytes in a row at or above 'A', per start position
  always_comb begin
    for (int i = 0; i < BUF_DEPTH - 2; i++) begin
      trip[i] = (store_r[i] >= rpd_pkg::CH_A) && (store_r[i+1] >= rpd_pkg::CH_A) &&
                (store_r[i+2] >= rpd_pkg::CH_A);
    end
  end

  // signature decode on the first three bytes
  always_comb begin
    sig_ok   = 1'b1;
    sig_kind = rpd_pkg::KIND_CMD;
    priority if (store_r[0] == rpd_pkg::CH_C && store_r[1] == rpd_pkg::CH_M &&
                 store_r[2] == rpd_pkg::CH_D) begin
      sig_kind = rpd_pkg::KIND_CMD;
    end else if (store_r[0] == rpd_pkg::CH_V && store_r[1] == rpd_pkg::CH_A &&
                 store_r[2] == rpd_pkg::CH_R) begin
      sig_kind = rpd_pkg::KIND_VAR;
    end else if (store_r[0] == rpd_pkg::CH_R && store_r[1] == rpd_pkg::CH_O &&
                 store_r[2] == rpd_pkg::CH_M) begin
      sig_kind = rpd_pkg::KIND_ROM;
    end else if (store_r[0] == rpd_pkg::CH_H && store_r[1] == rpd_pkg::CH_E &&
                 store_r[2] == rpd_pkg::CH_X) begin
      sig_kind = rpd_pkg::KIND_HEX;
    end else begin
      sig_ok = 1'b0;
    end
  end

  assign need    = FW'(rpd_pkg::pkt_len(kind_r));
  assign here    = (store_r[3] == device_id);
  assign crc_nxt = rpd_pkg::crc8_byte(crc_r, store_r[idx_r[IW-1:0]]);
  assign q_pop   = (state_r == S_IDLE) && q_valid && !out_v_r;
  assign res       = out_r;
  assign res_valid = out_v_r;

  // result fields of the packet just checked
  always_comb begin
    chk_res = '0;
    chk_res.packet_kind    = kind_r;
    chk_res.addressed_here = here;
    if (kind_r == rpd_pkg::KIND_CMD) begin
      chk_res.command_code = store_r[4];
      chk_res.command_tag  = {store_r[6], store_r[5]};
    end else if (kind_r == rpd_pkg::KIND_HEX) begin
      chk_res.hex_payload   = {store_r[11], store_r[10], store_r[9], store_r[8],
                               store_r[7], store_r[6], store_r[5], store_r[4]};
      chk_res.payload_taken = here && boot_r;
    end
  end

  // last accepted packet with the counters at the end of the request
  always_comb begin
    done_res = pres_r;
    done_res.crc_error_total    = err_r;
    done_res.hex_total          = hexc_r;
    done_res.boot_armed_flag    = boot_r;
    done_res.expected_hex_total = exph_r;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      err_r   <= '0;
      hexc_r  <= '0;
      boot_r  <= 1'b0;
      exph_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && res_ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            pend_r <= 1'b0;
            if (fill_r < DEPTH_F) fill_r <= fill_r + 1'b1;
            state_r <= S_EXAM;
          end
        end
        S_EXAM: begin
          if (fill_r < FW'(3)) begin
            state_r <= S_DONE;
          end else if (sig_ok) begin
            kind_r <= sig_kind;
            if (fill_r < FW'(rpd_pkg::pkt_len(sig_kind))) begin
              state_r <= S_DONE;
            end else begin
              crc_r   <= 8'h00;
              idx_r   <= '0;
              state_r <= S_CRC;
            end
          end else begin
            idx_r   <= FW'(1);
            state_r <= S_SCAN;
          end
        end
        S_CRC: begin
          crc_r <= crc_nxt;
          idx_r <= idx_r + 1'b1;
          if (idx_r == need - 1'b1) state_r <= S_CHK;
        end
        S_CHK: begin
          if (crc_r == 8'h00) begin
            pend_r <= 1'b1;
            pres_r <= chk_res;
            if (kind_r == rpd_pkg::KIND_CMD) begin
              if (here && store_r[4] == rpd_pkg::CMD_BOOT) begin
                boot_r <= 1'b1;
                exph_r <= {store_r[6], store_r[5]};
              end
            end else if (kind_r == rpd_pkg::KIND_HEX) begin
              if (here && boot_r) hexc_r <= hexc_r + 16'd1;
            end
            idx_r   <= need;
            state_r <= S_SHIFT;
          end else begin
            err_r   <= err_r + 16'd1;
            idx_r   <= FW'(1);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if ({1'b0, idx_r} + (FW+1)'(2) < {1'b0, fill_r}) begin
            if (trip[idx_r[IW-1:0]]) state_r <= S_SHIFT;
            else idx_r <= idx_r + 1'b1;
          end else begin
            fill_r  <= '0;
            state_r <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (idx_r == '0) begin
            state_r <= S_EXAM;
          end else begin
            idx_r  <= idx_r - 1'b1;
            fill_r <= fill_r - 1'b1;
          end
        end
        S_DONE: begin
          if (pend_r) begin
            out_v_r <= 1'b1;
            out_r   <= done_res;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // byte buffer: append at the fill point, shift left one place per cycle
  always_ff @(posedge clk) begin
    if (state_r == S_SHIFT && idx_r != '0) begin
      for (int j = 0; j < BUF_DEPTH - 1; j++) store_r[j] <= store_r[j+1];
    end else if (q_pop && fill_r < DEPTH_F) begin
      store_r[fill_r[IW-1:0]] <= q_data;
    end
  end

endmodule

@@ src/rs485_packet_deframer_crc8_unit.sv @@
// rs485_packet_deframer_crc8_unit: top level with byte queue, deframer and apb register
// depends on rpd_pkg, rpd_if, rpd_front, rpd_back
//
// Received bytes enter a two-entry queue and are handled one at a time by the
// deframer, which appends each byte to a BUF_DEPTH-entry buffer and checks for
// CMD, VAR, ROM or HEX packets. A packet check runs the CRC-8 one buffer byte
// per cycle and then shifts the buffer left one place per cycle to drop the
// packet before the buffer is examined again. A CRC failure or unknown
// signature scans for the next run of three bytes at or above 'A' and shifts
// the buffer to it, or empties the buffer if there is none; each further packet
// left in the buffer repeats the examination. A byte is only taken from the
// queue while the result register is empty. device_id sits at byte address 0
// of the APB port.
module rs485_packet_deframer_crc8_unit #(
  parameter int BUF_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  rpd_in_if.sink       in_ch,
  rpd_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic          q_valid;
  logic [7:0]    q_data;
  logic          q_pop;
  logic [7:0]    device_id_r;
  rpd_pkg::res_t res;
  logic          res_valid;

  // configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= 8'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == rpd_pkg::REG_DEVICE_ID) begin
      device_id_r <= cfg_pwdata[7:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == rpd_pkg::REG_DEVICE_ID) ? {24'h0, device_id_r} : 32'h0;

  // front queue
  rpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.rx_byte),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // deframer
  rpd_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .device_id (device_id_r),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_ch.ready)
  );

  // result channel
  assign out_ch.valid              = res_valid;
  assign out_ch.packet_kind        = res.packet_kind;
  assign out_ch.addressed_here     = res.addressed_here;
  assign out_ch.command_code       = res.command_code;
  assign out_ch.command_tag        = res.command_tag;
  assign out_ch.hex_payload        = res.hex_payload;
  assign out_ch.payload_taken      = res.payload_taken;
  assign out_ch.crc_error_total    = res.crc_error_total;
  assign out_ch.hex_total          = res.hex_total;
  assign out_ch.boot_armed_flag    = res.boot_armed_flag;
  assign out_ch.expected_hex_total = res.expected_hex_total;

`ifndef NO_ASSERTIONS
  a_taken: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.payload_taken |->
      res.packet_kind == rpd_pkg::KIND_HEX && res.addressed_here && res.boot_armed_flag)
    else $error("payload taken outside armed hex packet");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.packet_kind != rpd_pkg::KIND_CMD |->
      res.command_code == 8'h00 && res.command_tag == 16'h0000)
    else $error("command fields set on non-command packet");
  a_pay: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.packet_kind != rpd_pkg::KIND_HEX |-> res.hex_payload == 64'h0)
    else $error("payload set on non-hex packet");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && !res_valid)
    else $error("byte popped while result pending");
`endif

endmodule

@@ verif/testbench.sv @@
// testbench for rs485_packet_deframer_crc8_unit: byte streams of framed packets, noise and bad crc
// depends on rpd_pkg, rpd_if and the deframer rtl; predicts each report and checks it field by field
`timescale 1ns / 100ps

module testbench;

  localparam int STORE_DEPTH = 16;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_BYTES = 1025;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rpd_in_if  in_ch ();
  rpd_out_if out_ch ();

  rs485_packet_deframer_crc8_unit #(.BUF_DEPTH(STORE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [7:0]  rx_store [STORE_DEPTH];
  int unsigned rx_fill;
  logic [15:0] crc_fail_count;
  logic [15:0] hex_taken_count;
  logic        boot_on;
  logic [15:0] announced_hex;
  logic [7:0]  my_address;

  rpd_pkg::res_t expected_reports[$];
  int   fail_count;
  int   bytes_sent;
  int   idle_cycles;
  int   out_wait;
  int   out_count;
  int   out_seen;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reflected crc-8, polynomial 0x8c, lsb first
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 8'h8C) : (r >> 1);
    return r;
  endfunction

  function automatic int unsigned frame_length(input logic [1:0] kind);
    return (kind == rpd_pkg::KIND_CMD) ? 8 : (kind == rpd_pkg::KIND_VAR) ? 9 : 13;
  endfunction

  // append one byte, deframe, report the last packet accepted
  function automatic bit deframe_byte(input logic [7:0] b, output rpd_pkg::res_t rep);
    bit          got;
    bit          known;
    logic [1:0]  kind;
    int unsigned need;
    int unsigned adv;
    logic [7:0]  crc;
    got = 0;
    rep = '0;
    if (rx_fill < STORE_DEPTH) begin
      rx_store[rx_fill] = b;
      rx_fill++;
    end
    while (rx_fill >= 3) begin
      adv = 0;
      known = 1;
      if (rx_store[0] == rpd_pkg::CH_C && rx_store[1] == rpd_pkg::CH_M &&
          rx_store[2] == rpd_pkg::CH_D)
        kind = rpd_pkg::KIND_CMD;
      else if (rx_store[0] == rpd_pkg::CH_V && rx_store[1] == rpd_pkg::CH_A &&
               rx_store[2] == rpd_pkg::CH_R)
        kind = rpd_pkg::KIND_VAR;
      else if (rx_store[0] == rpd_pkg::CH_R && rx_store[1] == rpd_pkg::CH_O &&
               rx_store[2] == rpd_pkg::CH_M)
        kind = rpd_pkg::KIND_ROM;
      else if (rx_store[0] == rpd_pkg::CH_H && rx_store[1] == rpd_pkg::CH_E &&
               rx_store[2] == rpd_pkg::CH_X)
        kind = rpd_pkg::KIND_HEX;
      else known = 0;
      if (known) begin
        need = frame_length(kind);
        if (rx_fill < need) break;
        crc = 8'h00;
        for (int i = 0; i < need; i++) crc = crc_update(crc, rx_store[i]);
        if (crc == 8'h00) begin
          rep = '0;
          rep.packet_kind = kind;
          rep.addressed_here = (rx_store[3] == my_address);
          if (kind == rpd_pkg::KIND_CMD) begin
            rep.command_code = rx_store[4];
            rep.command_tag = {rx_store[6], rx_store[5]};
            if (rep.addressed_here && rep.command_code == rpd_pkg::CMD_BOOT) begin
              announced_hex = rep.command_tag;
              boot_on = 1'b1;
            end
          end else if (kind == rpd_pkg::KIND_HEX) begin
            for (int i = 0; i < 8; i++) rep.hex_payload[8*i +: 8] = rx_store[4 + i];
            if (rep.addressed_here && boot_on) begin
              hex_taken_count++;
              rep.payload_taken = 1'b1;
            end
          end
          got = 1;
          adv = need;
        end else begin
          crc_fail_count++;
        end
      end
      // resync at the next run of three bytes at or above 'A'
      if (adv == 0) begin
        for (int i = 1; i + 2 < rx_fill; i++) begin
          if (rx_store[i] >= rpd_pkg::CH_A && rx_store[i+1] >= rpd_pkg::CH_A &&
              rx_store[i+2] >= rpd_pkg::CH_A) begin
            adv = i;
            break;
          end
        end
      end
      if (adv == 0 || adv >= rx_fill) begin
        rx_fill = 0;
        break;
      end
      for (int i = 0; i + adv < rx_fill; i++) rx_store[i] = rx_store[i + adv];
      rx_fill -= adv;
    end
    if (got) begin
      rep.crc_error_total = crc_fail_count;
      rep.hex_total = hex_taken_count;
      rep.boot_armed_flag = boot_on;
      rep.expected_hex_total = announced_hex;
    end
    return got;
  endfunction

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    rpd_pkg::res_t rep;
    rpd_pkg::res_t exp_rep;
    idle_cycles++;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      idle_cycles = 0;
      if (deframe_byte(in_ch.rx_byte, rep)) expected_reports.push_back(rep);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      idle_cycles = 0;
      out_count++;
      if (expected_reports.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (out_ch.packet_kind !== exp_rep.packet_kind) begin
          $error("packet_kind expected %0d actual %0d", exp_rep.packet_kind, out_ch.packet_kind);
          fail_count++;
        end
        if (out_ch.addressed_here !== exp_rep.addressed_here) begin
          $error("addressed_here expected %0d actual %0d",
                 exp_rep.addressed_here, out_ch.addressed_here);
          fail_count++;
        end
        if (out_ch.command_code !== exp_rep.command_code) begin
          $error("command_code expected %0h actual %0h",
                 exp_rep.command_code, out_ch.command_code);
          fail_count++;
        end
        if (out_ch.command_tag !== exp_rep.command_tag) begin
          $error("command_tag expected %0h actual %0h", exp_rep.command_tag, out_ch.command_tag);
          fail_count++;
        end
        if (out_ch.hex_payload !== exp_rep.hex_payload) begin
          $error("hex_payload expected %0h actual %0h", exp_rep.hex_payload, out_ch.hex_payload);
          fail_count++;
        end
        if (out_ch.payload_taken !== exp_rep.payload_taken) begin
          $error("payload_taken expected %0d actual %0d",
                 exp_rep.payload_taken, out_ch.payload_taken);
          fail_count++;
        end
        if (out_ch.crc_error_total !== exp_rep.crc_error_total) begin
          $error("crc_error_total expected %0d actual %0d",
                 exp_rep.crc_error_total, out_ch.crc_error_total);
          fail_count++;
        end
        if (out_ch.hex_total !== exp_rep.hex_total) begin
          $error("hex_total expected %0d actual %0d", exp_rep.hex_total, out_ch.hex_total);
          fail_count++;
        end
        if (out_ch.boot_armed_flag !== exp_rep.boot_armed_flag) begin
          $error("boot_armed_flag expected %0d actual %0d",
                 exp_rep.boot_armed_flag, out_ch.boot_armed_flag);
          fail_count++;
        end
        if (out_ch.expected_hex_total !== exp_rep.expected_hex_total) begin
          $error("expected_hex_total expected %0d actual %0d",
                 exp_rep.expected_hex_total, out_ch.expected_hex_total);
          fail_count++;
        end
      end
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side stalls, a fresh wait drawn after each accepted result
  always @(negedge clk) begin
    if (out_seen != out_count) begin
      out_seen = out_count;
      out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    end
    if (out_wait > 0) begin
      out_ch.ready <= 1'b0;
      out_wait--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one byte request, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // framed packet: signature, address, body bytes, crc; optionally one bit flipped
  task automatic send_packet(input logic [1:0] kind, input logic [7:0] addr,
                             input logic [63:0] body, input bit corrupt);
    logic [7:0]  pkt[$];
    logic [7:0]  crc;
    int unsigned len;
    int          pos;
    len = frame_length(kind);
    case (kind)
      rpd_pkg::KIND_CMD: pkt = '{rpd_pkg::CH_C, rpd_pkg::CH_M, rpd_pkg::CH_D};
      rpd_pkg::KIND_VAR: pkt = '{rpd_pkg::CH_V, rpd_pkg::CH_A, rpd_pkg::CH_R};
      rpd_pkg::KIND_ROM: pkt = '{rpd_pkg::CH_R, rpd_pkg::CH_O, rpd_pkg::CH_M};
      default:           pkt = '{rpd_pkg::CH_H, rpd_pkg::CH_E, rpd_pkg::CH_X};
    endcase
    pkt.push_back(addr);
    for (int i = 0; i < len - 5; i++) pkt.push_back(body[8*i +: 8]);
    crc = 8'h00;
    foreach (pkt[i]) crc = crc_update(crc, pkt[i]);
    pkt.push_back(crc);
    if (corrupt) begin
      pos = $urandom_range(0, len - 1);
      pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (pkt[i]) send_byte(pkt[i]);
  endtask

  // block goes idle: input drained, results in, then the tail of any work
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // apb write, setup then access
  task automatic write_device_id(input logic [7:0] id);
    settle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(rpd_pkg::REG_DEVICE_ID) << 2;
    cfg_pwdata <= {24'h0, id};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    my_address = id;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // every kind, boot arming and hex capture at the reset address
  task automatic test_packet_kinds();
    send_packet(rpd_pkg::KIND_VAR, 8'd1, 64'h00000000_FFFFFFFF, 0);
    send_packet(rpd_pkg::KIND_ROM, 8'd9, 64'hFFFFFFFF_FFFFFFFF, 0);
    send_packet(rpd_pkg::KIND_HEX, 8'd1, 64'h01234567_89ABCDEF, 0);
    send_packet(rpd_pkg::KIND_CMD, 8'd1, {40'h0, 16'hFFFF, rpd_pkg::CMD_BOOT}, 0);
    send_packet(rpd_pkg::KIND_HEX, 8'd1, 64'h00000000_00000000, 0);
    send_packet(rpd_pkg::KIND_HEX, 8'd2, 64'hFEDCBA98_76543210, 0);
    send_packet(rpd_pkg::KIND_CMD, 8'd1, {40'h0, 16'h0000, 8'hFF}, 0);
  endtask

  // crc failure, unknown signature, noise below the letters, resync in the middle
  task automatic test_errors_and_resync();
    send_packet(rpd_pkg::KIND_CMD, 8'd1, 64'h0000_1234_18, 1);
    send_byte(8'h5A); send_byte(8'h5A); send_byte(8'h5A); send_byte(8'h00);
    send_byte(8'h40); send_byte(8'h20); send_byte(8'h00);
    send_byte(8'h7F);
    send_packet(rpd_pkg::KIND_VAR, 8'd1, 64'h11223344, 0);
    send_packet(rpd_pkg::KIND_HEX, 8'd1, 64'hA5A5A5A5_5A5A5A5A, 1);
    send_packet(rpd_pkg::KIND_ROM, 8'd0, 64'h80808080_80808080, 0);
  endtask

  // address at both extremes of the register
  task automatic test_address_extremes();
    write_device_id(8'd0);
    send_packet(rpd_pkg::KIND_CMD, 8'd0, {40'h0, 16'h0102, rpd_pkg::CMD_BOOT}, 0);
    send_packet(rpd_pkg::KIND_HEX, 8'd0, 64'hDEADBEEF_CAFEF00D, 0);
    write_device_id(8'd255);
    send_packet(rpd_pkg::KIND_HEX, 8'd255, 64'h0F0F0F0F_F0F0F0F0, 0);
    send_packet(rpd_pkg::KIND_HEX, 8'd0, 64'h1, 0);
    settle();
  endtask

  // mostly valid packets with random content, some broken, some noise
  task automatic test_random_traffic();
    int          roll;
    logic [7:0]  addr;
    logic [63:0] body;
    int          target;
    int          phase;
    target = bytes_sent + RANDOM_BYTES;
    phase = 0;
    while (bytes_sent < target) begin
      if (bytes_sent > target - RANDOM_BYTES + 300 * (phase + 1) && phase < 3) begin
        phase++;
        write_device_id(8'($urandom_range(0, 255)));
      end
      roll = $urandom_range(0, 99);
      addr = ($urandom_range(0, 1) != 0) ? my_address : 8'($urandom_range(0, 255));
      body = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) body[7:0] = rpd_pkg::CMD_BOOT;
      if (roll < 75) begin
        send_packet(2'($urandom_range(0, 3)), addr, body, 0);
      end else if (roll < 88) begin
        send_packet(2'($urandom_range(0, 3)), addr, body, 1);
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rx_fill = 0;
    crc_fail_count = '0;
    hex_taken_count = '0;
    boot_on = 1'b0;
    announced_hex = '0;
    my_address = 8'd1;
    fail_count = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    out_wait = 0;
    out_count = 0;
    out_seen = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_packet_kinds();
    test_errors_and_resync();
    test_address_extremes();
    test_random_traffic();
    write_device_id(8'd1);
    settle();

    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ rs485_packet_deframer_crc8_unit.f @@
src/rpd_pkg.sv
src/rpd_if.sv
src/rpd_front.sv
src/rpd_back.sv
src/rs485_packet_deframer_crc8_unit.sv
verif/testbench.sv
